// ----- rtl/core/jcm_pkg.sv -----
package jcm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int Q_W         = FRAC_BITS + 8;
    localparam int CNT_W       = $clog2(Q_W);
    localparam int ACC_W       = Q_W + 8;

    localparam logic [Q_W-1:0] S_FULL  = Q_W'(255 << FRAC_BITS);
    localparam logic [Q_W-1:0] S_TOP   = Q_W'(96 << FRAC_BITS);
    localparam logic [Q_W-1:0] S_CAP   = Q_W'(64 << FRAC_BITS);
    localparam logic [Q_W-1:0] S_HALF  = Q_W'(32 << FRAC_BITS);
    localparam logic [Q_W-1:0] C_RED   = Q_W'(192 << FRAC_BITS);
    localparam logic [Q_W-1:0] C_GREEN = Q_W'(128 << FRAC_BITS);
    localparam logic [Q_W-1:0] C_BLUE  = Q_W'(64 << FRAC_BITS);

    typedef enum logic [1:0] {
        ACT_FIRST = 2'd0,
        ACT_MORE  = 2'd1,
        ACT_MAP   = 2'd2
    } t_action;

    typedef struct packed {
        logic range_first;
        logic range_more;
        logic map_load;
        logic setup;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic out_full;
    } t_stat;

    function automatic logic [7:0] f_channel(input logic [Q_W-1:0] s,
                                             input logic [Q_W-1:0] c);
        logic [Q_W-1:0]   d;
        logic [Q_W-1:0]   n;
        logic [ACC_W-1:0] acc;
        d = (s >= c) ? (s - c) : (c - s);
        n = (d >= S_TOP) ? '0 : (S_TOP - d);
        if (n > S_CAP) begin
            n = S_CAP;
        end
        acc = {8'b0, n} * ACC_W'(255) + {8'b0, S_HALF};
        return acc[6 + FRAC_BITS +: 8];
    endfunction

endpackage

// ----- rtl/core/jcm_ctrl.sv -----
module jcm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_action,
    output logic          o_ready,
    input  jcm_pkg::t_stat i_stat,
    output jcm_pkg::t_cmd  o_cmd
);
    import jcm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.range_first = (i_action == ACT_FIRST);
                    o_cmd.range_more  = (i_action == ACT_MORE);
                    if (i_action == ACT_MAP) begin
                        o_cmd.map_load = 1'b1;
                        n_state        = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt       = CNT_W'(Q_W - 1);
                n_state     = i_stat.bypass ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_map_to_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_MAP) |=> r_state == ST_SETUP)
        else $error("map word did not start setup");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && r_cnt == '0) |=> r_state == ST_FINISH)
        else $error("divider overran its bit count");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_full)
        else $error("output register overwritten");
`endif

endmodule

// ----- rtl/core/jcm_datapath.sv -----
module jcm_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [jcm_pkg::TDATA_W-1:0]  i_sample,
    input  jcm_pkg::t_cmd                i_cmd,
    output jcm_pkg::t_stat               o_stat,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [23:0]                  o_data
);
    import jcm_pkg::*;

    localparam int S = SAMPLE_BITS;

    logic signed [S-1:0] r_low, r_high, r_sample;
    logic signed [S-1:0] w_in;
    logic signed [S:0]   w_off_full, w_span_full;
    logic [S-1:0]        w_off;
    logic [S+7:0]        w_prod;
    logic                w_flat, w_below, w_above;
    logic [S-1:0]        r_span, r_rem;
    logic [Q_W-1:0]      r_dvd, r_quot;
    logic [S:0]          w_trial;
    logic                w_fit;
    logic                r_out_valid;
    logic [23:0]         r_out_data;

    assign w_in        = signed'(i_sample[S-1:0]);
    assign w_off_full  = {r_sample[S-1], r_sample} - {r_low[S-1], r_low};
    assign w_span_full = {r_high[S-1], r_high} - {r_low[S-1], r_low};
    assign w_off       = w_off_full[S-1:0];
    assign w_prod      = {8'b0, w_off} * (S + 8)'(255);
    assign w_flat      = (r_high <= r_low);
    assign w_below     = (r_sample <= r_low);
    assign w_above     = (r_sample >= r_high);

    assign w_trial = {r_rem, r_dvd[Q_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_span});

    assign o_stat.bypass   = w_flat || w_below || w_above;
    assign o_stat.out_full = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cmd.range_first) begin
            r_low  <= w_in;
            r_high <= w_in;
        end else if (i_cmd.range_more) begin
            if (w_in < r_low) begin
                r_low <= w_in;
            end
            if (w_in > r_high) begin
                r_high <= w_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_load) begin
            r_sample <= w_in;
        end
        if (i_cmd.setup) begin
            r_span <= w_span_full[S-1:0];
            r_rem  <= w_prod[S+7:8];
            r_dvd  <= {w_prod[7:0], {FRAC_BITS{1'b0}}};
            r_quot <= (w_flat || w_below) ? '0 : S_FULL;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_fit ? (w_trial[S-1:0] - r_span) : w_trial[S-1:0];
            r_dvd  <= {r_dvd[Q_W-2:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {f_channel(r_quot, C_BLUE), f_channel(r_quot, C_GREEN),
                           f_channel(r_quot, C_RED)};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef SYNTHESIS
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.range_first || i_cmd.range_more) |=> r_low <= r_high)
        else $error("range minimum above maximum");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < r_span)
        else $error("divider remainder out of bound");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded word not presented");
`endif

endmodule

// ----- rtl/core/jet_color_map.sv -----
// Jet color map for one single-band frame streamed twice. Range words (tuser 0 restarts
// the frame, tuser 1 continues) track the signed minimum and maximum, with no output.
// A map word (tuser 2) scales the sample to 0..255 in Q8.8 against that range and
// returns red, green and blue; from acceptance it passes through setup, then a restoring
// divider producing one quotient bit per cycle until the 16-bit quotient is complete,
// then the color stage, which loads the output register. When the sample sits at or
// outside the range or the range is flat, the scaled value is 0 or 255 and the divider is
// skipped. tuser 3 is dropped. A finished word waits in the output register while the
// next input word is taken.
module jet_color_map (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [jcm_pkg::TDATA_W-1:0]  s_axis_tdata,  // sample
    input  logic [1:0]                   s_axis_tuser,  // action
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata   // red, green, blue
);
    import jcm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    jcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    jcm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

// ----- tb/sv/jet_color_map_tb.sv -----
`timescale 1ns / 100ps

module jet_color_map_tb;
    import jcm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WORDS_TOTAL  = 1700;
    localparam int CALM_AFTER   = 1500;
    localparam int PAUSE_AT     = 800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct {
        logic [1:0]         act;
        logic signed [15:0] smp;
        bit                 given;
        t_rgb               rgb;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;  // sample
    logic [1:0]           s_axis_tuser = '0;  // action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;       // red, green, blue

    logic signed [15:0]   range_lo = '0;
    logic signed [15:0]   range_hi = '0;
    t_rgb                 rgb_due[$];
    t_row                 directed[$];

    int  errors = 0;
    int  mismatches = 0;
    int  rgb_seen = 0;
    int  words_sent = 0;
    int  range_words = 0;
    int  map_words = 0;
    int  dropped_words = 0;
    int  frames = 0;
    int  idle_cycles = 0;
    int  send_gap_odds = 4;
    int  recv_stall_odds = 5;
    int  stall_left = 0;
    bit  calm = 1'b0;

    jet_color_map u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] jet_ramp(input longint s, input longint centre);
        longint c;
        longint d;
        longint n;
        c = centre << FRAC_BITS;
        d = (s >= c) ? (s - c) : (c - s);
        n = (d >= (96 << FRAC_BITS)) ? 0 : ((96 << FRAC_BITS) - d);
        if (n > (64 << FRAC_BITS)) begin
            n = 64 << FRAC_BITS;
        end
        return 8'((255 * n + (32 << FRAC_BITS)) >> (6 + FRAC_BITS));
    endfunction

    function automatic longint scaled_level(input logic signed [15:0] smp);
        longint v;
        longint lo;
        longint hi;
        longint q;
        v  = smp;
        lo = range_lo;
        hi = range_hi;
        if (hi <= lo || v <= lo) begin
            return 0;
        end
        if (v >= hi) begin
            return 255 << FRAC_BITS;
        end
        q = ((255 * (v - lo)) << FRAC_BITS) / (hi - lo);
        return (q > (255 << FRAC_BITS)) ? (255 << FRAC_BITS) : q;
    endfunction

    task automatic track_word(input logic [1:0] act, input logic signed [15:0] smp,
                              output bit has_rgb, output t_rgb rgb);
        longint s;
        has_rgb = 1'b0;
        rgb = '0;
        if (act == ACT_FIRST) begin
            range_lo = smp;
            range_hi = smp;
        end else if (act == ACT_MORE) begin
            if (smp < range_lo) range_lo = smp;
            if (smp > range_hi) range_hi = smp;
        end else if (act == ACT_MAP) begin
            s = scaled_level(smp);
            rgb.red   = jet_ramp(s, 192);
            rgb.green = jet_ramp(s, 128);
            rgb.blue  = jet_ramp(s, 64);
            has_rgb = 1'b1;
        end
    endtask

    function automatic logic signed [15:0] clip16(input int v);
        if (v < -32768) return 16'sh8000;
        if (v > 32767) return 16'sh7fff;
        return 16'(v);
    endfunction

    task automatic send_word(input logic [1:0] act, input logic signed [15:0] smp,
                             input bit given, input t_rgb given_rgb);
        bit   has_rgb;
        t_rgb rgb;
        if (!calm && send_gap_odds != 0 && $urandom_range(0, send_gap_odds) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_word(act, smp, has_rgb, rgb);
        if (has_rgb) begin
            rgb_due = {rgb_due, (given ? given_rgb : rgb)};
        end
        case (act)
            ACT_FIRST, ACT_MORE: range_words++;
            ACT_MAP:             map_words++;
            default:             dropped_words++;
        endcase
        if (act != ACT_UNUSED) begin
            words_sent++;
        end
        @(negedge i_clk);
    endtask

    // hold the sender until every pending color word is back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (rgb_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [1:0] act, input int smp, input bit given,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_row row;
        row.act = act;
        row.smp = clip16(smp);
        row.given = given;
        row.rgb.red = r;
        row.rgb.green = g;
        row.rgb.blue = b;
        directed = {directed, row};
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 39) == 0) begin
            send_word(ACT_UNUSED, 16'($urandom_range(0, 65535)), 1'b0, '0);
        end
    endtask

    task automatic run_frame();
        int  kind;
        int  spread;
        int  base;
        int  n_range;
        int  n_map;
        int  v;
        bit  broken;
        int  odds[3];
        odds = '{0, 3, 8};
        send_gap_odds   = odds[$urandom_range(0, 2)];
        recv_stall_odds = odds[$urandom_range(0, 2)];
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            spread = 65535;
        end else if (kind == 3) begin
            spread = 0;
        end else if (kind < 6) begin
            spread = $urandom_range(1, 8);
        end else begin
            spread = $urandom_range(1, 4095);
        end
        base    = int'($urandom_range(0, 65535 - spread)) - 32768;
        n_range = $urandom_range(1, 12);
        n_map   = $urandom_range(1, 16);
        broken  = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < n_range; i++) begin
            maybe_noise();
            v = base + int'($urandom_range(0, spread));
            send_word((i == 0 && !broken) ? ACT_FIRST : ACT_MORE, clip16(v), 1'b0, '0);
        end
        for (int i = 0; i < n_map; i++) begin
            maybe_noise();
            if ($urandom_range(0, 7) == 0) begin
                v = int'($urandom_range(0, 65535)) - 32768;
            end else begin
                v = base - spread / 8 - 1 + int'($urandom_range(0, spread + spread / 4 + 2));
            end
            send_word(ACT_MAP, clip16(v), 1'b0, '0);
        end
        frames++;
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && recv_stall_odds != 0 &&
                     $urandom_range(0, recv_stall_odds) == 0) begin
            stall_left <= $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_rgb'(m_axis_tdata);
            rgb_seen++;
            if (rgb_due.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected color word %h", m_axis_tdata);
                end
            end else begin
                want = rgb_due.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("color word %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 rgb_seen, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        bit paused;
        paused = 1'b0;

        add_row(ACT_MAP,      0,      1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_MAP,      32767,  1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_UNUSED,   1234,   0, 0, 0, 0);
        add_row(ACT_FIRST,    -32768, 0, 0, 0, 0);
        add_row(ACT_MORE,     32767,  0, 0, 0, 0);
        add_row(ACT_MAP,      -32768, 1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_MAP,      32767,  1, 8'd131, 8'd0, 8'd0);
        add_row(ACT_MAP,      0,      0, 0, 0, 0);
        add_row(ACT_MAP,      -1,     0, 0, 0, 0);
        add_row(ACT_FIRST,    100,    0, 0, 0, 0);
        add_row(ACT_MORE,     100,    0, 0, 0, 0);
        add_row(ACT_MAP,      100,    1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_MAP,      50,     1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_MORE,     300,    0, 0, 0, 0);
        add_row(ACT_MAP,      50,     1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_MAP,      400,    1, 8'd131, 8'd0, 8'd0);
        add_row(ACT_MAP,      200,    0, 0, 0, 0);
        add_row(ACT_UNUSED,   -5,     0, 0, 0, 0);
        add_row(ACT_FIRST,    -1,     0, 0, 0, 0);
        add_row(ACT_MORE,     1,      0, 0, 0, 0);
        add_row(ACT_MAP,      0,      0, 0, 0, 0);
        add_row(ACT_MAP,      1,      1, 8'd131, 8'd0, 8'd0);
        add_row(ACT_MORE,     -100,   0, 0, 0, 0);
        add_row(ACT_MAP,      -100,   1, 8'd0,   8'd0, 8'd128);
        add_row(ACT_MAP,      -50,    0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            send_word(directed[i].act, directed[i].smp, directed[i].given, directed[i].rgb);
        end

        while (words_sent < WORDS_TOTAL) begin
            calm = (words_sent >= CALM_AFTER);
            if ((!paused && words_sent >= PAUSE_AT) || $urandom_range(0, 15) == 0) begin
                paused = 1'b1;
                hold_until_drained();
            end
            run_frame();
        end

        s_axis_tvalid <= 1'b0;
        while (rgb_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rgb_due.size() != 0) begin
            errors += rgb_due.size();
            $display("%0d color words never arrived", rgb_due.size());
        end

        $display("covered %0d frames: %0d range words, %0d map words, %0d dropped words",
                 frames, range_words, map_words, dropped_words);
        $display("checked %0d color words, %0d mismatches", rgb_seen, mismatches);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/jcm_pkg.sv
rtl/core/jcm_ctrl.sv
rtl/core/jcm_datapath.sv
rtl/core/jet_color_map.sv
tb/sv/jet_color_map_tb.sv
